/* design/knn_pkg.sv */
package knn_pkg;

  // Field widths of the channels and the configuration port
  localparam int FUNC_W     = 2;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 6;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 38;
  localparam int K_W        = 7;
  localparam int NS_W       = 7;
  localparam int NG_W       = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_DIST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_K_NEIGHBOURS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GENE_COUNT   = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // take the accepted item, perform loads, clear the sum
    logic sel_init;   // start a selection: clear taken bits, fill the cache tag
    logic scan;       // read one distance of the column and advance
    logic pick;       // record the nearest sample of this pass
    logic sum_issue;  // read one neighbour and its data value
    logic emit;       // load the result register
  } knn_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err;
    logic hit;
    logic k_zero;
    logic scan_last;
    logic pos_last;
    logic sum_last;
    logic sum_busy;
    logic out_free;
  } knn_status_t;

endpackage

/* design/knn_item_if.sv */
interface knn_item_if;
  import knn_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ROW_W-1:0]  row_index;
  logic [COL_W-1:0]  sample_index;
  logic [VAL_W-1:0]  value;

  modport source (output valid, func, row_index, sample_index, value, input ready);
  modport sink   (input valid, func, row_index, sample_index, value, output ready);

endinterface

/* design/knn_result_if.sv */
interface knn_result_if;
  import knn_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] gene;
  logic [COL_W-1:0] sample;
  logic [SUM_W-1:0] smoothed_sum;
  logic             error;

  modport source (output valid, gene, sample, smoothed_sum, error, input ready);
  modport sink   (input valid, gene, sample, smoothed_sum, error, output ready);

endinterface

/* design/knn_ram.sv */
module knn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/knn_ctrl.sv */
module knn_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [knn_pkg::FUNC_W-1:0]    in_func,
  output logic                          in_ready,
  input  knn_pkg::knn_status_t          status,
  output knn_pkg::knn_cmd_t             cmd
);
  import knn_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_PASS    = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_PICK    = 3'd4;
  localparam logic [2:0] S_SUM     = 3'd5;
  localparam logic [2:0] S_SUMWAIT = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_func == FUNC_QUERY) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (status.err) begin
          state_next = S_EMIT;
        end else begin
          cmd.sel_init = !status.hit;
          if (status.k_zero) begin
            state_next = S_EMIT;
          end else if (status.hit) begin
            state_next = S_SUM;
          end else begin
            state_next = S_PASS;
          end
        end
      end
      S_PASS: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_next = status.pos_last ? S_SUM : S_PASS;
      end
      S_SUM: begin
        cmd.sum_issue = 1'b1;
        if (status.sum_last) begin
          state_next = S_SUMWAIT;
        end
      end
      S_SUMWAIT: begin
        if (!status.sum_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/knn_datapath.sv */
module knn_datapath #(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_GENES   = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0]    cfg_data,
  // accepted item payload
  input  logic [knn_pkg::FUNC_W-1:0]        item_func,
  input  logic [knn_pkg::ROW_W-1:0]         item_row,
  input  logic [knn_pkg::COL_W-1:0]         item_col,
  input  logic [knn_pkg::VAL_W-1:0]         item_value,
  // result register
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [knn_pkg::ROW_W-1:0]         out_gene,
  output logic [knn_pkg::COL_W-1:0]         out_sample,
  output logic [knn_pkg::SUM_W-1:0]         out_sum,
  output logic                              out_error,
  // control
  input  knn_pkg::knn_cmd_t                 cmd,
  output knn_pkg::knn_status_t              status
);
  import knn_pkg::*;

  localparam int SW   = $clog2(MAX_SAMPLES);
  localparam int DDEP = MAX_SAMPLES * MAX_SAMPLES;
  localparam int GDEP = MAX_GENES * MAX_SAMPLES;
  localparam int DAW  = $clog2(DDEP);
  localparam int GAW  = $clog2(GDEP);

  // Configuration and cache tag
  logic [K_W-1:0]   k_neighbours;
  logic [NS_W-1:0]  sample_count;
  logic [NG_W-1:0]  gene_count;
  logic             cache_valid;
  logic [COL_W-1:0] cached_sample;

  // Query held during its work
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;

  // Selection
  logic [SW-1:0]          scan_idx;
  logic [SW-1:0]          scan_idx_d;
  logic                   cand_d;
  logic                   found;
  logic [SW-1:0]          best;
  logic [VAL_W-1:0]       best_dist;
  logic [MAX_SAMPLES-1:0] taken;
  logic [SW-1:0]          pos;

  // Summation
  logic [SW-1:0]    sum_idx;
  logic             sum_v1;
  logic             sum_v2;
  logic [SUM_W-1:0] acc;

  // Memory ports
  logic             dist_we;
  logic [DAW-1:0]   dist_waddr;
  logic [DAW-1:0]   dist_raddr;
  logic [VAL_W-1:0] dist_rdata;
  logic             data_we;
  logic [GAW-1:0]   data_waddr;
  logic [GAW-1:0]   data_raddr;
  logic [VAL_W-1:0] data_rdata;
  logic [SW-1:0]    nb_rdata;

  logic [31:0] load_lin;
  logic [31:0] scan_lin;
  logic [31:0] sum_lin;
  logic        dist_in_range;
  logic        data_in_range;
  logic        cfg_known;

  logic [8:0] n9;
  logic [8:0] k9;
  logic [8:0] n_minus;
  logic [8:0] k_minus;

  // Loads write directly on acceptance
  assign load_lin      = 32'(item_row) * 32'(MAX_SAMPLES) + 32'(item_col);
  assign dist_in_range = (32'(item_row) < 32'(MAX_SAMPLES)) && (32'(item_col) < 32'(MAX_SAMPLES));
  assign data_in_range = (32'(item_row) < 32'(MAX_GENES)) && (32'(item_col) < 32'(MAX_SAMPLES));
  assign dist_we       = cmd.capture && (item_func == FUNC_DIST) && dist_in_range;
  assign data_we       = cmd.capture && (item_func == FUNC_DATA) && data_in_range;
  assign dist_waddr    = load_lin[DAW-1:0];
  assign data_waddr    = load_lin[GAW-1:0];

  // Column scan: row scan_idx, column of the queried sample
  assign scan_lin   = 32'(scan_idx) * 32'(MAX_SAMPLES) + 32'(col_q);
  assign dist_raddr = scan_lin[DAW-1:0];

  // Gene row at the neighbour column
  assign sum_lin    = 32'(row_q) * 32'(MAX_SAMPLES) + 32'(nb_rdata);
  assign data_raddr = sum_lin[GAW-1:0];

  knn_ram #(.WIDTH(VAL_W), .DEPTH(DDEP)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (item_value),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  knn_ram #(.WIDTH(VAL_W), .DEPTH(GDEP)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (item_value),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  knn_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_nb_ram (
    .clk   (clk),
    .we    (cmd.pick),
    .waddr (pos),
    .wdata (best),
    .raddr (sum_idx),
    .rdata (nb_rdata)
  );

  // Clamp the sample count and derive the last indexes
  assign n9 = ({2'b00, sample_count} > 9'(MAX_SAMPLES)) ? 9'(MAX_SAMPLES) : {2'b00, sample_count};
  assign k9 = {2'b00, k_neighbours};
  assign n_minus = n9 - 9'd1;
  assign k_minus = k9 - 9'd1;

  assign cfg_known = (cfg_index == CFG_K_NEIGHBOURS) || (cfg_index == CFG_SAMPLE_COUNT) ||
                     (cfg_index == CFG_GENE_COUNT);

  always_comb begin
    status.err = (k9 > n9) || ({3'b000, col_q} >= n9) || ({1'b0, row_q} >= gene_count) ||
                 (32'(row_q) >= 32'(MAX_GENES));
    status.hit       = cache_valid && (cached_sample == col_q);
    status.k_zero    = (k_neighbours == '0);
    status.scan_last = (scan_idx == n_minus[SW-1:0]);
    status.pos_last  = (pos == k_minus[SW-1:0]);
    status.sum_last  = (sum_idx == k_minus[SW-1:0]);
    status.sum_busy  = sum_v1 || sum_v2;
    status.out_free  = !out_valid || out_ready;
  end

  // Configuration registers and cache tag
  always_ff @(posedge clk) begin
    if (rst) begin
      k_neighbours  <= K_W'(2);
      sample_count  <= NS_W'(64);
      gene_count    <= NG_W'(1024);
      cache_valid   <= 1'b0;
      cached_sample <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_K_NEIGHBOURS: k_neighbours <= cfg_data[K_W-1:0];
          CFG_SAMPLE_COUNT: sample_count <= cfg_data[NS_W-1:0];
          CFG_GENE_COUNT:   gene_count   <= cfg_data[NG_W-1:0];
          default: ;
        endcase
      end
      if ((cfg_we && cfg_known) || dist_we) begin
        cache_valid <= 1'b0;
      end else if (cmd.sel_init) begin
        cache_valid   <= 1'b1;
        cached_sample <= col_q;
      end
    end
  end

  // Query fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_q <= item_row;
      col_q <= item_col;
    end
  end

  // Selection control
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_d   <= 1'b0;
      found    <= 1'b0;
      scan_idx <= '0;
      pos      <= '0;
      taken    <= '0;
    end else begin
      cand_d <= cmd.scan && !taken[scan_idx];
      if (cmd.sel_init || cmd.pick) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_idx <= scan_idx + SW'(1);
        end
        if (cand_d && (!found || (dist_rdata < best_dist))) begin
          found <= 1'b1;
        end
      end
      if (cmd.sel_init) begin
        pos   <= '0;
        taken <= '0;
      end else if (cmd.pick) begin
        pos         <= pos + SW'(1);
        taken[best] <= 1'b1;
      end
    end
  end

  // Running minimum; strict compare keeps the lower index on ties
  always_ff @(posedge clk) begin
    scan_idx_d <= scan_idx;
    if (cand_d && (!found || (dist_rdata < best_dist))) begin
      best      <= scan_idx_d;
      best_dist <= dist_rdata;
    end
  end

  // Summation pipeline: neighbour read, data read, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_idx <= '0;
      sum_v1  <= 1'b0;
      sum_v2  <= 1'b0;
    end else begin
      sum_v1 <= cmd.sum_issue;
      sum_v2 <= sum_v1;
      if (cmd.capture) begin
        sum_idx <= '0;
      end else if (cmd.sum_issue) begin
        sum_idx <= sum_idx + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= '0;
    end else if (sum_v2) begin
      acc <= acc + SUM_W'(data_rdata);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_gene   <= row_q;
      out_sample <= col_q;
      out_sum    <= status.err ? '0 : acc;
      out_error  <= status.err;
    end
  end

endmodule

/* design/knn_neighbour_sum.sv */
// Channel   Dir  Carries                                          Transaction
// item      in   func, row_index, sample_index, value             valid && ready
// result    out  gene, sample, smoothed_sum, error                valid && ready
// cfg       in   cfg_index, cfg_data (k, samples, genes)          cfg_we
//
// Loads are accepted in the idle state and may arrive back to back. A cache hit query
// goes straight to summation, one that fails its range checks straight to its result.
// A new sample first runs k selection passes over its distance column, one read per cycle.
// Reset clears the state machine and cache tag and sets the default configuration;
// no clearing pass. A stalled result holds in its register; loads are still accepted,
// and the next query waits only at the point of writing its own result.
module knn_neighbour_sum #(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_GENES   = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0] cfg_data,
  knn_item_if.sink                       item,
  knn_result_if.source                   result
);
  import knn_pkg::*;

  knn_cmd_t    cmd;
  knn_status_t status;

  // Sequencer: accepts an item in its idle state, walks selection and summation
  knn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_func  (item.func),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Stores, selection unit, accumulator and result register
  knn_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_GENES   (MAX_GENES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_func  (item.func),
    .item_row   (item.row_index),
    .item_col   (item.sample_index),
    .item_value (item.value),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .out_gene   (result.gene),
    .out_sample (result.sample),
    .out_sum    (result.smoothed_sum),
    .out_error  (result.error),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

/* verif/knn_tb_pkg.sv */
`timescale 1ns / 100ps
package knn_tb_pkg;
  import knn_pkg::*;

  localparam int MAX_SAMPLES  = 64;
  localparam int MAX_GENES    = 1024;
  localparam int REPORT_LIMIT = 10;

  // Codes with no meaning in the block: the item is dropped, the write is dropped
  localparam logic [FUNC_W-1:0]    FUNC_IDLE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] gene;
    logic [COL_W-1:0] sample;
    logic [SUM_W-1:0] total;
    logic             error;
  } smoothed_answer_t;

  class smoothing_scoreboard;
    logic [VAL_W-1:0] dist_mem [MAX_SAMPLES*MAX_SAMPLES];
    logic [VAL_W-1:0] expr_mem [MAX_GENES*MAX_SAMPLES];
    int unsigned      nearest [MAX_SAMPLES];
    int unsigned      nearest_col;
    bit               nearest_ok;
    logic [K_W-1:0]   k_reg;
    logic [NS_W-1:0]  ns_reg;
    logic [NG_W-1:0]  ng_reg;
    smoothed_answer_t pending_answers [$];
    int               mismatches;

    function new();
      k_reg       = 2;
      ns_reg      = 64;
      ng_reg      = 1024;
      nearest_ok  = 0;
      nearest_col = 0;
      mismatches  = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_K_NEIGHBOURS: k_reg = data[K_W-1:0];
        CFG_SAMPLE_COUNT: ns_reg = data[NS_W-1:0];
        CFG_GENE_COUNT:   ng_reg = data[NG_W-1:0];
        default:          return;
      endcase
      nearest_ok = 0;
    endfunction

    // Pick the k closest samples of a distance column, lower index first on ties
    function void pick_nearest(int unsigned col, int unsigned n, int unsigned k);
      bit          taken [MAX_SAMPLES];
      int unsigned best;
      bit          found;
      foreach (taken[i]) taken[i] = 0;
      for (int unsigned pos = 0; pos < k; pos++) begin
        best  = 0;
        found = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (!taken[i] && (!found ||
              dist_mem[i*MAX_SAMPLES+col] < dist_mem[best*MAX_SAMPLES+col])) begin
            best  = i;
            found = 1;
          end
        end
        taken[best]  = 1;
        nearest[pos] = best;
      end
      nearest_col = col;
      nearest_ok  = 1;
    endfunction

    function void note_item(logic [FUNC_W-1:0] func, logic [ROW_W-1:0] row,
                            logic [COL_W-1:0] col, logic [VAL_W-1:0] val);
      smoothed_answer_t ans;
      int unsigned      n;
      int unsigned      gl;
      logic [SUM_W-1:0] acc;
      case (func)
        FUNC_DIST: begin
          if (row < MAX_SAMPLES) begin
            dist_mem[row*MAX_SAMPLES+col] = val;
            nearest_ok = 0;
          end
        end
        FUNC_DATA: begin
          if (row < MAX_GENES) expr_mem[row*MAX_SAMPLES+col] = val;
        end
        FUNC_QUERY: begin
          n          = (ns_reg > MAX_SAMPLES) ? MAX_SAMPLES : ns_reg;
          gl         = (ng_reg > MAX_GENES) ? MAX_GENES : ng_reg;
          acc        = '0;
          ans.gene   = row;
          ans.sample = col;
          ans.error  = (k_reg > n) || (row >= gl) || (col >= n);
          if (!ans.error) begin
            if (!nearest_ok || nearest_col != col) pick_nearest(col, n, k_reg);
            for (int unsigned i = 0; i < k_reg; i++)
              acc += expr_mem[row*MAX_SAMPLES+nearest[i]];
          end
          ans.total = acc;
          pending_answers.push_back(ans);
        end
        default: ;
      endcase
    endfunction

    function void check_answer(logic [ROW_W-1:0] gene, logic [COL_W-1:0] sample,
                               logic [SUM_W-1:0] total, logic error);
      smoothed_answer_t want;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: gene %0d sample %0d sum %h error %b",
                   gene, sample, total, error);
        return;
      end
      want = pending_answers.pop_front();
      if (gene !== want.gene || sample !== want.sample ||
          total !== want.total || error !== want.error) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: gene %0d/%0d sample %0d/%0d sum %h/%h error %b/%b",
                   want.gene, gene, want.sample, sample, want.total, total,
                   want.error, error);
      end
    endfunction
  endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import knn_pkg::*;
  import knn_tb_pkg::*;

  // Longest quiet stretch of a correct run is a full selection with k = n = 64
  // plus a receiver stall; allow many times that.
  localparam int STALL_LIMIT   = 40000;
  // Loads are written on acceptance, so a short pause covers any trailing load
  localparam int SETTLE_CYCLES = 32;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  knn_item_if   item_ch ();
  knn_result_if result_ch ();

  knn_neighbour_sum #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .MAX_GENES  (MAX_GENES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  smoothing_scoreboard sb = new();

  // Stimulus view of the current setting (clamped as the block clamps it)
  int k_now;
  int n_now;
  int g_now;
  // Columns and gene rows fully loaded in this phase: only these get good queries
  int fill_cols [$];
  int fill_genes [$];
  int last_col;
  // Sender bursts and receiver stalls
  int burst_left;
  bit sender_steady;
  int rx_hold;
  int rx_cycle;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: mostly ready with random stalls, and a long stall-free stretch
  // in every window so that back-to-back results get through too.
  initial begin
    rx_hold  = 0;
    rx_cycle = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 1536 < 384) begin
        result_ch.ready <= 1'b1;
      end else if (rx_hold != 0) begin
        rx_hold--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 16);
      end
    end
  end

  // Check every result transaction against the oldest predicted answer
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_answer(result_ch.gene, result_ch.sample, result_ch.smoothed_sum,
                      result_ch.error);
  end

  // Watchdog: end the run when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Half of the distances come from a tiny range so that ties are common
  function automatic logic [VAL_W-1:0] distance_value();
    return ($urandom_range(0, 1) == 0) ? VAL_W'($urandom_range(0, 3)) : VAL_W'($urandom);
  endfunction

  // Drive one item and hold it until the block takes it. Between bursts, drop
  // valid for a random gap; in a steady phase, keep the stream back to back.
  task automatic send_item(input logic [FUNC_W-1:0] f, input int row, input int col,
                           input logic [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid        <= 1'b1;
    item_ch.func         <= f;
    item_ch.row_index    <= ROW_W'(row);
    item_ch.sample_index <= COL_W'(col);
    item_ch.value        <= val;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(f, ROW_W'(row), COL_W'(col), val);
  endtask

  // Drop valid, wait for every answer, then let trailing loads finish
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.note_config(idx, data);
  endtask

  // Query a loaded gene on a loaded column (an idle item if none is loaded); revisit
  // the last column half the time so that the cached neighbor list gets reused.
  task automatic good_query();
    if (fill_cols.size() == 0 || fill_genes.size() == 0) begin
      send_item(FUNC_IDLE, $urandom_range(0, 1023), $urandom_range(0, 63), $urandom);
      return;
    end
    if ($urandom_range(0, 1)) last_col = fill_cols[$urandom_range(0, fill_cols.size() - 1)];
    send_item(FUNC_QUERY, fill_genes[$urandom_range(0, fill_genes.size() - 1)], last_col,
              $urandom);
  endtask

  // Query that must come back flagged (too many neighbors, gene or sample out of range), else a good query
  task automatic bad_query();
    if (k_now > n_now)
      send_item(FUNC_QUERY, $urandom_range(0, 1023), $urandom_range(0, 63), $urandom);
    else if (g_now < MAX_GENES && (n_now == MAX_SAMPLES || $urandom_range(0, 1)))
      send_item(FUNC_QUERY, $urandom_range(g_now, 1023), $urandom_range(0, 63), $urandom);
    else if (n_now < MAX_SAMPLES)
      send_item(FUNC_QUERY, $urandom_range(0, 1023), $urandom_range(n_now, 63), $urandom);
    else
      good_query();
  endtask

  task automatic random_item();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      good_query();
    end else if (roll < 47) begin
      bad_query();
    end else if (roll < 65) begin
      // Rewrite distances of a queried column: invalidates the cached list
      if (fill_cols.size() != 0)
        send_item(FUNC_DIST, $urandom_range(0, n_now - 1),
                  fill_cols[$urandom_range(0, fill_cols.size() - 1)], distance_value());
      else
        send_item(FUNC_DIST, $urandom_range(0, MAX_SAMPLES - 1), $urandom_range(0, 63),
                  distance_value());
    end else if (roll < 70) begin
      // Distance row past the matrix: must be dropped
      send_item(FUNC_DIST, $urandom_range(MAX_SAMPLES, 1023), $urandom_range(0, 63), $urandom);
    end else if (roll < 90) begin
      if (fill_genes.size() != 0 && $urandom_range(0, 9) < 7)
        send_item(FUNC_DATA, fill_genes[$urandom_range(0, fill_genes.size() - 1)],
                  $urandom_range(0, n_now - 1), $urandom);
      else
        send_item(FUNC_DATA, $urandom_range(0, 1023), $urandom_range(0, 63), $urandom);
    end else begin
      send_item(FUNC_IDLE, $urandom_range(0, 1023), $urandom_range(0, 63), $urandom);
    end
  endtask

  // One setting: write all registers (upper bits of the narrow ones random),
  // load whole distance columns and gene rows, then mix loads, queries and noise.
  task automatic run_phase(input int k_val, input int ns_val, input int ng_val,
                           input int n_cols, input int n_genes, input int n_random,
                           input bit steady);
    int c;
    int g;
    settle();
    write_reg(CFG_K_NEIGHBOURS, {4'($urandom), 7'(k_val)});
    write_reg(CFG_SPARE, 11'($urandom));
    write_reg(CFG_SAMPLE_COUNT, {4'($urandom), 7'(ns_val)});
    write_reg(CFG_GENE_COUNT, 11'(ng_val));
    cfg_we <= 1'b0;
    k_now         = k_val;
    n_now         = (ns_val > MAX_SAMPLES) ? MAX_SAMPLES : ns_val;
    g_now         = (ng_val > MAX_GENES) ? MAX_GENES : ng_val;
    sender_steady = steady;
    burst_left    = 0;
    fill_cols.delete();
    fill_genes.delete();
    // The first column and gene are the highest in use
    for (int j = 0; j < n_cols && n_now > 0; j++) begin
      c = (j == 0) ? n_now - 1 : $urandom_range(0, n_now - 1);
      fill_cols.push_back(c);
      for (int i = 0; i < n_now; i++) send_item(FUNC_DIST, i, c, distance_value());
    end
    for (int j = 0; j < n_genes && g_now > 0 && n_now > 0; j++) begin
      g = (j == 0) ? g_now - 1 : $urandom_range(0, g_now - 1);
      fill_genes.push_back(g);
      for (int i = 0; i < n_now; i++) send_item(FUNC_DATA, g, i, $urandom);
    end
    last_col = (fill_cols.size() != 0) ? fill_cols[0] : 0;
    repeat (n_random) random_item();
  endtask

  // Hand-picked items for k = 3, four samples, eight genes
  task automatic directed_items();
    // Column 2: sample 0 far away, samples 1 and 2 tie at zero
    send_item(FUNC_DIST, 0, 2, 32'hFFFF_FFFF);
    send_item(FUNC_DIST, 1, 2, 32'h0000_0000);
    send_item(FUNC_DIST, 2, 2, 32'h0000_0000);
    send_item(FUNC_DIST, 3, 2, 32'h0001_0000);
    // Largest values so that the sum needs the upper bits
    send_item(FUNC_DATA, 7, 0, 32'h0000_0001);
    send_item(FUNC_DATA, 7, 1, 32'hFFFF_FFFF);
    send_item(FUNC_DATA, 7, 2, 32'hFFFF_FFFF);
    send_item(FUNC_DATA, 7, 3, 32'hFFFF_FFFF);
    send_item(FUNC_QUERY, 7, 2, '0);
    send_item(FUNC_QUERY, 7, 2, '0);
    // Gene and sample out of range
    send_item(FUNC_QUERY, 8, 2, '0);
    send_item(FUNC_QUERY, 1023, 2, '0);
    send_item(FUNC_QUERY, 7, 4, '0);
    send_item(FUNC_QUERY, 7, 63, '0);
    send_item(FUNC_IDLE, 1023, 63, 32'hFFFF_FFFF);
    // Distance rows past the matrix must not alias onto low rows
    send_item(FUNC_DIST, 64, 2, 32'h0000_0000);
    send_item(FUNC_DIST, 1023, 63, 32'h0000_0000);
    send_item(FUNC_QUERY, 7, 2, '0);
    // Three-way tie at zero: the lowest indexes win
    send_item(FUNC_DIST, 0, 2, 32'h0000_0000);
    send_item(FUNC_QUERY, 7, 2, '0);
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_K_NEIGHBOURS;
    cfg_data             <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.func         <= FUNC_IDLE;
    item_ch.row_index    <= '0;
    item_ch.sample_index <= '0;
    item_ch.value        <= '0;
    burst_left    = 0;
    sender_steady = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    run_phase(3, 4, 8, 0, 0, 0, 1'b1);
    directed_items();
    // Single sample and gene: k = 1
    run_phase(1, 1, 1, 1, 1, 100, 1'b0);
    // Zero neighbors: sum of nothing, no error
    run_phase(0, 5, 16, 2, 3, 120, 1'b0);
    // Gene count above the limit clamps to the full store
    run_phase(4, 8, 2047, 3, 4, 330, 1'b0);
    // Largest k and sample count: k exceeds the clamped samples, every query flagged
    run_phase(127, 127, 1024, 0, 0, 60, 1'b1);
    // Full matrix: k = n = 64, highest sample and gene
    run_phase(64, 64, 1024, 1, 2, 50, 1'b0);
    // No samples and no genes in use
    run_phase(7, 0, 0, 0, 0, 50, 1'b0);
    run_phase(5, 12, 300, 3, 5, 260, 1'b1);
    // k equal to the sample count
    run_phase(12, 12, 1, 1, 1, 120, 1'b0);
    settle();

    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
